/* hw/rtl/eqpq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eqpq_pkg
// Shared widths, register indexes, reset values and types for the encoder
// and press qualifier.
// ----------------------------------------------------------------------------
package eqpq_pkg;

  // Internal state widths
  localparam int CountWidth = 16;   // encoder count, 8..32
  localparam int TimerWidth = 16;   // press timer, 10..32

  // Port field widths
  localparam int PosWidth   = 16;
  localparam int StepWidth  = 2;
  localparam int TicksWidth = 16;

  // Configuration port
  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 16;
  localparam int LimitWidth   = 16;

  // Width used for duration vs. limit compares
  localparam int CmpWidth = (TimerWidth > LimitWidth) ? TimerWidth : LimitWidth;

  localparam logic [CfgIdxWidth-1:0] CfgShortLimit = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgLongLimit  = 2'd1;

  localparam logic [LimitWidth-1:0] ShortLimitRst = 16'd300;
  localparam logic [LimitWidth-1:0] LongLimitRst  = 16'd600;

  // Step codes
  localparam logic signed [StepWidth-1:0] StepNone = 2'sb00;
  localparam logic signed [StepWidth-1:0] StepUp   = 2'sb01;
  localparam logic signed [StepWidth-1:0] StepDown = 2'sb11;

  // One accepted input sample
  typedef struct packed {
    logic enc_clock;
    logic enc_data;
    logic button_level;
  } in_item_t;

  // Button classifier status for one tick
  typedef struct packed {
    logic held;
    logic short_click;
    logic long_click;
  } btn_status_t;

endpackage
`default_nettype wire

/* hw/rtl/eqpq_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eqpq_in_if
// Sample channel: valid/ready handshake with the three pin levels.
// ----------------------------------------------------------------------------
interface eqpq_in_if;
  logic valid;
  logic ready;
  logic enc_clock;
  logic enc_data;
  logic button_level;

  modport source (output valid, output enc_clock, output enc_data,
                  output button_level, input ready);
  modport sink   (input valid, input enc_clock, input enc_data,
                  input button_level, output ready);
endinterface
`default_nettype wire

/* hw/rtl/eqpq_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eqpq_out_if
// Result channel: valid/ready handshake with position, step and click data.
// ----------------------------------------------------------------------------
interface eqpq_out_if;
  import eqpq_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [PosWidth-1:0]   position;
  logic signed [StepWidth-1:0]  step;
  logic                         button_held;
  logic                         short_click;
  logic                         long_click;
  logic        [TicksWidth-1:0] press_ticks;

  modport source (output valid, output position, output step, output button_held,
                  output short_click, output long_click, output press_ticks,
                  input ready);
  modport sink   (input valid, input position, input step, input button_held,
                  input short_click, input long_click, input press_ticks,
                  output ready);
endinterface
`default_nettype wire

/* hw/rtl/eqpq_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eqpq_encoder
// Rotary encoder edge detector and wrapping up/down counter.
// ----------------------------------------------------------------------------
module eqpq_encoder (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 advance_i,
  input  wire logic                                 enc_clock_i,
  input  wire logic                                 enc_data_i,
  output logic signed [eqpq_pkg::PosWidth-1:0]      position_o,
  output logic signed [eqpq_pkg::StepWidth-1:0]     step_o
);
  import eqpq_pkg::*;

  logic                  prev_clock_q;
  logic [CountWidth-1:0] count_q, count_d;
  logic                  rise;

  assign rise = !prev_clock_q && enc_clock_i;

  always_comb begin
    count_d = count_q;
    step_o  = StepNone;
    if (rise) begin
      if (enc_data_i) begin
        count_d = count_q - CountWidth'(1);
        step_o  = StepDown;
      end else begin
        count_d = count_q + CountWidth'(1);
        step_o  = StepUp;
      end
    end
  end

  // low bits of the new count, zero-extended if the count is narrower
  assign position_o = PosWidth'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_clock_q <= 1'b1;
      count_q      <= '0;
    end else if (advance_i) begin
      prev_clock_q <= enc_clock_i;
      count_q      <= count_d;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/eqpq_button.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eqpq_button
// Press timer with saturation, click classifier and the two limit registers.
// ----------------------------------------------------------------------------
module eqpq_button (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 advance_i,
  input  wire logic                                 button_level_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [eqpq_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  wire logic [eqpq_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output eqpq_pkg::btn_status_t                     status_o,
  output logic [eqpq_pkg::TicksWidth-1:0]           press_ticks_o
);
  import eqpq_pkg::*;

  logic [LimitWidth-1:0] short_limit_q, long_limit_q;
  logic                  held_q, held_d;
  logic [TimerWidth-1:0] timer_q, timer_d, timer_inc, duration;
  logic                  pressed;

  assign pressed   = !button_level_i;
  assign timer_inc = (timer_q == '1) ? timer_q : timer_q + TimerWidth'(1);

  always_comb begin
    held_d               = held_q;
    timer_d              = timer_q;
    duration             = '0;
    status_o.short_click = 1'b0;
    status_o.long_click  = 1'b0;
    if (held_q) begin
      timer_d = timer_inc;
      if (!pressed) begin
        held_d               = 1'b0;
        duration             = timer_inc;
        status_o.short_click = (duration != '0) &&
                               (CmpWidth'(duration) < CmpWidth'(short_limit_q));
        status_o.long_click  = CmpWidth'(duration) > CmpWidth'(long_limit_q);
      end
    end else if (pressed) begin
      held_d  = 1'b1;
      timer_d = '0;
    end
    status_o.held = held_d;
  end

  assign press_ticks_o = TicksWidth'(duration);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      timer_q <= '0;
    end else if (advance_i) begin
      held_q  <= held_d;
      timer_q <= timer_d;
    end
  end

  // limit registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_limit_q <= ShortLimitRst;
      long_limit_q  <= LongLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgShortLimit: short_limit_q <= LimitWidth'(cfg_data_i);
        CfgLongLimit:  long_limit_q  <= LimitWidth'(cfg_data_i);
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/encoder_and_press_qualifier.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_and_press_qualifier
// Rotary encoder decoder with push-button press timing and click
// classification, one result transaction per sample transaction.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Payload
//  item_i    in   valid/ready        enc_clock, enc_data, button_level
//  result_o  out  valid/ready        position, step, button_held,
//                                    short_click, long_click, press_ticks
//  cfg_*     in   write enable only  cfg_idx_i, cfg_data_i (16 bit)
//
//  The result follows the sample transaction through an input register, then
//  one pass of encoder/button logic into the result register.
//  Throughput is one transaction per cycle while result_o is ready; both
//  stages advance together.
//  A stalled result register holds and backs up into the input register;
//  a new sample is still taken while the input register is empty or moving.
//  Reset is asynchronous: limits return to 300/600, count, timer and held
//  clear, the previous encoder clock level reads high.
// ----------------------------------------------------------------------------
module encoder_and_press_qualifier (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  eqpq_in_if.sink                                 item_i,
  eqpq_out_if.source                              result_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [eqpq_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  wire logic [eqpq_pkg::CfgDataWidth-1:0]  cfg_data_i
);
  import eqpq_pkg::*;

  // Input register stage
  logic     in_valid_q, in_valid_d;
  in_item_t in_item_q;
  logic     in_accept;

  // Result register stage
  logic                         out_valid_q, out_valid_d;
  logic                         out_room;
  logic                         advance;
  logic signed [PosWidth-1:0]   position_q;
  logic signed [StepWidth-1:0]  step_q;
  logic                         held_q;
  logic                         short_q;
  logic                         long_q;
  logic        [TicksWidth-1:0] ticks_q;

  // Combinational results from the submodules
  logic signed [PosWidth-1:0]   position_c;
  logic signed [StepWidth-1:0]  step_c;
  btn_status_t                  status_c;
  logic        [TicksWidth-1:0] ticks_c;

  // The result register has room when empty or when it drains this cycle;
  // the sample moves forward (and state updates) only then.
  assign out_room  = !out_valid_q || result_o.ready;
  assign advance   = in_valid_q && out_room;
  assign item_i.ready = !in_valid_q || out_room;
  assign in_accept = item_i.valid && item_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sample capture
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q.enc_clock    <= item_i.enc_clock;
      in_item_q.enc_data     <= item_i.enc_data;
      in_item_q.button_level <= item_i.button_level;
    end
  end

  eqpq_encoder u_encoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .enc_clock_i (in_item_q.enc_clock),
    .enc_data_i  (in_item_q.enc_data),
    .position_o  (position_c),
    .step_o      (step_c)
  );

  eqpq_button u_button (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .button_level_i (in_item_q.button_level),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .status_o       (status_c),
    .press_ticks_o  (ticks_c)
  );

  // Result capture
  always_ff @(posedge clk_i) begin
    if (advance) begin
      position_q <= position_c;
      step_q     <= step_c;
      held_q     <= status_c.held;
      short_q    <= status_c.short_click;
      long_q     <= status_c.long_click;
      ticks_q    <= ticks_c;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.position    = position_q;
  assign result_o.step        = step_q;
  assign result_o.button_held = held_q;
  assign result_o.short_click = short_q;
  assign result_o.long_click  = long_q;
  assign result_o.press_ticks = ticks_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // a sample leaving the input register always lands as a valid result
  a_advance_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded after advance");

  // a click is only reported on a release with a nonzero duration
  a_click_on_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (short_q || long_q)) |-> (!held_q && ticks_q != '0))
    else $error("click flagged without a release");

  // while held there is no release, so no duration is reported
  a_held_no_ticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && held_q) |-> (ticks_q == '0 && !short_q && !long_q))
    else $error("press duration reported while button held");

  // a stalled result stays valid and keeps its payload until taken
  a_stall_holds_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |=>
    (out_valid_q && $stable(position_q) && $stable(ticks_q)))
    else $error("result changed while stalled");

endmodule
`default_nettype wire
